@@ hw/rtl/sevseg_pkg.sv @@
// ----------------------------------------------------------------------------
// sevseg_pkg: shared types and constants of the seven-segment text scanner
// Character codes, segment patterns and the words that pass between modules.
// ----------------------------------------------------------------------------
package sevseg_pkg;

   // item kinds on the request channel
   typedef enum logic {
      ACTION_CHAR = 1'b0,
      ACTION_TICK = 1'b1
   } action_type;

   // character codes that mean something to the scanner
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   // segment patterns, a at bit 0 through decimal point at bit 7
   localparam logic [7:0] SEG_MINUS     = 8'h40;
   localparam int         SEG_POINT_BIT = 7;

   // divider period after reset
   localparam logic [15:0] PERIOD_RESET = 16'd500;

   localparam int ENABLE_W = 3;

   // character word handed to the cell store
   typedef struct packed {
      logic       strobe;
      logic       first;
      logic [7:0] code;
   } char_cmd_type;

   // one result word
   typedef struct packed {
      logic [7:0]          segments;
      logic [ENABLE_W-1:0] digit_enable;
      logic                measure_request;
   } rsp_word_type;

   // decimal digit to segment pattern
   function automatic logic [7:0] glyph(input logic [3:0] digit);
      logic [7:0] pattern;
      case (digit)
         4'd0:    pattern = 8'h3F;
         4'd1:    pattern = 8'h06;
         4'd2:    pattern = 8'h5B;
         4'd3:    pattern = 8'h4F;
         4'd4:    pattern = 8'h66;
         4'd5:    pattern = 8'h6D;
         4'd6:    pattern = 8'h7D;
         4'd7:    pattern = 8'h07;
         4'd8:    pattern = 8'h7F;
         4'd9:    pattern = 8'h6F;
         default: pattern = 8'h00;
      endcase
      return pattern;
   endfunction

endpackage

@@ hw/rtl/sevseg_if.sv @@
// ----------------------------------------------------------------------------
// sevseg channel interfaces
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface sevseg_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] character;
   logic       first;

   modport source (output valid, action, character, first, input ready);
   modport sink   (input valid, action, character, first, output ready);
endinterface

interface sevseg_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [7:0]                      segments;
   logic [sevseg_pkg::ENABLE_W-1:0] digit_enable;
   logic                            measure_request;

   modport source (output valid, segments, digit_enable, measure_request, input ready);
   modport sink   (input valid, segments, digit_enable, measure_request, output ready);
endinterface

@@ hw/rtl/seven_segment_text_scanner.sv @@
// ----------------------------------------------------------------------------
// seven_segment_text_scanner: multiplexed seven-segment display driver
// Fills display cells from number text and scans them out on ticks.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one word per cycle while ready is high: a character
//   of number text (action = char) or a scan tick (action = tick). Digits
//   and minus fill the next cell, a dot sets the point of the cell written
//   last if any cell is free; first restarts filling without clearing cells.
//   rsp_chan returns one word per tick: the cell's segments, a one-hot digit
//   enable and the measurement request. Characters return nothing.
//   csr_write_enable/csr_write_data set the divider period (reset 500); the
//   request is raised once every period + 1 ticks.
//   Between request accept and result accept lie one input register and
//   one result register. One word is taken every cycle that ready is high.
//   When rsp_chan stalls, the result register holds, a tick waits in the
//   input register and req_chan.ready drops; characters keep flowing past a
//   held result since they produce none.
//   Reset clears all cells, fill and scan positions and the divider.
// ----------------------------------------------------------------------------
module seven_segment_text_scanner #(
   parameter int DIGITS    = 3,
   parameter int MAX_CHARS = 16
) (
   input  logic        clock,
   input  logic        reset,
   sevseg_req_if.sink  req_chan,
   sevseg_rsp_if.source rsp_chan,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import sevseg_pkg::*;

   localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   logic         stage_valid_ff, stage_valid_in;
   logic         stage_action_ff;
   logic [7:0]   stage_char_ff;
   logic         stage_first_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;
   logic [15:0]  period_ff, period_in;

   logic         is_tick, out_take, stage_go, tick_go, req_take;
   char_cmd_type char_cmd;
   rsp_word_type scan_word;
   logic [IDX_W-1:0] cell_index;
   logic [7:0]   cell_data;

   // handshake and stage advance
   always_comb begin
      is_tick        = stage_action_ff == ACTION_TICK;
      out_take       = !out_valid_ff || rsp_chan.ready;
      stage_go       = stage_valid_ff && (!is_tick || out_take);
      tick_go        = stage_go && is_tick;
      req_take       = req_chan.valid && req_chan.ready;
      stage_valid_in = req_take || (stage_valid_ff && !stage_go);
      out_valid_in   = tick_go || (out_valid_ff && !rsp_chan.ready);
      period_in      = csr_write_enable ? csr_write_data : period_ff;
   end

   assign req_chan.ready = !stage_valid_ff || stage_go;

   // character word toward the cell store
   always_comb begin
      char_cmd.strobe = stage_go && !is_tick;
      char_cmd.first  = stage_first_ff;
      char_cmd.code   = stage_char_ff;
   end

   sevseg_cells #(
      .DIGITS    (DIGITS),
      .MAX_CHARS (MAX_CHARS),
      .IDX_W     (IDX_W)
   ) u_cells (
      .clock    (clock),
      .reset    (reset),
      .char_cmd (char_cmd),
      .rd_index (cell_index),
      .rd_data  (cell_data)
   );

   sevseg_scan #(
      .DIGITS (DIGITS),
      .IDX_W  (IDX_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick_go),
      .period     (period_ff),
      .cell_data  (cell_data),
      .cell_index (cell_index),
      .rsp_word   (scan_word)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         period_ff      <= PERIOD_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         period_ff      <= period_in;
      end
   end

   // input and result payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_action_ff <= req_chan.action;
         stage_char_ff   <= req_chan.character;
         stage_first_ff  <= req_chan.first;
      end
      if (tick_go) begin
         out_word_ff <= scan_word;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.segments        = out_word_ff.segments;
   assign rsp_chan.digit_enable    = out_word_ff.digit_enable;
   assign rsp_chan.measure_request = out_word_ff.measure_request;

endmodule

@@ hw/rtl/sevseg_cells.sv @@
// ----------------------------------------------------------------------------
// sevseg_cells: display cell store and fill logic
// Turns characters into segment patterns and writes them to successive cells.
// ----------------------------------------------------------------------------
module sevseg_cells #(
   parameter int DIGITS    = 3,
   parameter int MAX_CHARS = 16,
   parameter int IDX_W     = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sevseg_pkg::char_cmd_type char_cmd,
   input  logic [IDX_W-1:0]         rd_index,
   output logic [7:0]               rd_data
);
   import sevseg_pkg::*;

   localparam int FILL_W  = $clog2(DIGITS + 1);
   localparam int CHARS_W = $clog2(MAX_CHARS + 1);

   logic [7:0]         cells_ff [DIGITS];
   logic [7:0]         cells_in [DIGITS];
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [CHARS_W-1:0] chars_ff, chars_in;

   logic [FILL_W-1:0]  fill_now;
   logic [CHARS_W-1:0] chars_now;
   logic               take;
   logic               is_digit, is_minus, is_dot;
   logic [7:0]         pattern;

   // a new string restarts the fill before the character is handled
   always_comb begin
      fill_now  = char_cmd.first ? '0 : fill_ff;
      chars_now = char_cmd.first ? '0 : chars_ff;
      take      = char_cmd.strobe && (fill_now < FILL_W'(DIGITS))
                  && (chars_now < CHARS_W'(MAX_CHARS));
      is_digit  = (char_cmd.code >= CHAR_ZERO) && (char_cmd.code <= CHAR_NINE);
      is_minus  = char_cmd.code == CHAR_MINUS;
      is_dot    = char_cmd.code == CHAR_DOT;
      pattern   = is_digit ? glyph(4'(char_cmd.code - CHAR_ZERO)) : SEG_MINUS;
   end

   // next fill position, character count and cell contents
   always_comb begin
      fill_in  = char_cmd.strobe ? fill_now : fill_ff;
      chars_in = char_cmd.strobe ? chars_now : chars_ff;
      for (int i = 0; i < DIGITS; i++) begin
         cells_in[i] = cells_ff[i];
      end
      if (take) begin
         chars_in = chars_now + 1'b1;
         if (is_digit || is_minus) begin
            fill_in = fill_now + 1'b1;
         end
         for (int i = 0; i < DIGITS; i++) begin
            if ((is_digit || is_minus) && fill_now == FILL_W'(i)) begin
               cells_in[i] = pattern;
            end
            if (is_dot && fill_now == FILL_W'(i + 1)) begin
               cells_in[i][SEG_POINT_BIT] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         chars_ff <= '0;
         for (int i = 0; i < DIGITS; i++) begin
            cells_ff[i] <= '0;
         end
      end else begin
         fill_ff  <= fill_in;
         chars_ff <= chars_in;
         for (int i = 0; i < DIGITS; i++) begin
            cells_ff[i] <= cells_in[i];
         end
      end
   end

   // scan read port
   assign rd_data = cells_ff[rd_index];

endmodule

@@ hw/rtl/sevseg_scan.sv @@
// ----------------------------------------------------------------------------
// sevseg_scan: scan position and measurement divider
// Picks the lit cell on each tick and counts ticks toward the request pulse.
// ----------------------------------------------------------------------------
module sevseg_scan #(
   parameter int DIGITS = 3,
   parameter int IDX_W  = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     tick,
   input  logic [15:0]              period,
   input  logic [7:0]               cell_data,
   output logic [IDX_W-1:0]         cell_index,
   output sevseg_pkg::rsp_word_type rsp_word
);
   import sevseg_pkg::*;

   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [15:0]      div_ff, div_in;
   logic [16:0]      count;
   logic [3:0]       scan_wide;
   logic             wrap;

   // divider count is compared at full width before it is stored
   always_comb begin
      count = {1'b0, div_ff} + 17'd1;
      wrap  = count > {1'b0, period};
      scan_wide = 4'(scan_ff);
      scan_in = scan_ff;
      div_in  = div_ff;
      if (tick) begin
         scan_in = (scan_ff == IDX_W'(DIGITS - 1)) ? '0 : scan_ff + 1'b1;
         div_in  = wrap ? '0 : count[15:0];
      end
   end

   // result word for the current cell
   always_comb begin
      rsp_word.segments        = cell_data;
      rsp_word.measure_request = wrap;
      for (int i = 0; i < ENABLE_W; i++) begin
         rsp_word.digit_enable[i] = scan_wide == 4'(i);
      end
   end

   assign cell_index = scan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         div_ff  <= '0;
      end else begin
         scan_ff <= scan_in;
         div_ff  <= div_in;
      end
   end

endmodule
